/* rtl/chme_pkg.sv */
package chme_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // contents of one cell
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } ent_t;

  // request token walking down the row
  typedef struct packed {
    logic               act;
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               done;   // finished, just rides to the end
    logic               shift;  // delete in progress: pull right neighbor left
    logic               ins;    // store took a fresh cell
    status_t            status;
    logic [VALUE_W-1:0] rdv;
  } tok_t;

endpackage

/* rtl/chme_if.sv */
interface chme_req_if;
  import chme_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface chme_rsp_if;
  import chme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [VALUE_W-1:0]       read_value;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

/* rtl/chme_cell.sv */
module chme_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  chme_pkg::tok_t tok_i,
  input  chme_pkg::ent_t nbr_i,
  output chme_pkg::ent_t ent_o,
  output chme_pkg::tok_t tok_o
);
  import chme_pkg::*;

  ent_t ent_r, ent_nxt;
  tok_t tok_r, tok_nxt;

  always_comb begin
    ent_nxt = ent_r;
    tok_nxt = tok_i;
    if (tok_i.act && !tok_i.done) begin
      if (tok_i.shift) begin
        // compaction after a delete
        ent_nxt = nbr_i;
        if (!nbr_i.vld) tok_nxt.done = 1'b1;
      end else if (ent_r.vld && ent_r.key == tok_i.key) begin
        unique case (tok_i.op)
          OP_STORE: begin
            ent_nxt.value  = tok_i.value;
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_OK;
          end
          OP_LOOKUP: begin
            tok_nxt.rdv    = ent_r.value;
            tok_nxt.done   = 1'b1;
            tok_nxt.status = ST_OK;
          end
          OP_DELETE: begin
            ent_nxt        = nbr_i;
            tok_nxt.status = ST_OK;
            if (nbr_i.vld) tok_nxt.shift = 1'b1;
            else           tok_nxt.done  = 1'b1;
          end
          default: tok_nxt.done = 1'b1;
        endcase
      end else if (!ent_r.vld) begin
        // first empty cell: end of the occupied run
        tok_nxt.done = 1'b1;
        unique case (tok_i.op)
          OP_STORE: begin
            ent_nxt.vld    = 1'b1;
            ent_nxt.key    = tok_i.key;
            ent_nxt.value  = tok_i.value;
            tok_nxt.ins    = 1'b1;
            tok_nxt.status = ST_OK;
          end
          OP_LOOKUP, OP_DELETE: tok_nxt.status = ST_MISS;
          default: tok_nxt.status = ST_OK;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
      tok_r.act <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
      tok_r.act <= tok_nxt.act;
    end
    ent_r.key    <= ent_nxt.key;
    ent_r.value  <= ent_nxt.value;
    tok_r.op     <= tok_nxt.op;
    tok_r.key    <= tok_nxt.key;
    tok_r.value  <= tok_nxt.value;
    tok_r.done   <= tok_nxt.done;
    tok_r.shift  <= tok_nxt.shift;
    tok_r.ins    <= tok_nxt.ins;
    tok_r.status <= tok_nxt.status;
    tok_r.rdv    <= tok_nxt.rdv;
  end

  assign ent_o = ent_r;
  assign tok_o = tok_r;

endmodule

/* rtl/chained_hash_map_engine.sv */
// channel | dir | handshake   | payload
// in_req  | in  | valid/ready | opcode, key, value
// out_rsp | out | valid/ready | status, read_value, entry_count
//
// Entries sit packed at the front of a row of POOL_ENTRIES cells. A request
// moves one cell per clock and always runs the full row; the next request is
// accepted only once the result of this one has left the pending register.
// Synchronous active-low reset empties every cell at once; no clearing pass.
// A result waiting on out_rsp does not block the next accept; a second finished
// result holds in a pending register and in_req.ready stays low until it moves out.
module chained_hash_map_engine #(
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  chme_req_if.sink          in_req,
  chme_rsp_if.source        out_rsp
);
  import chme_pkg::*;

  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);

  tok_t tok_in;
  tok_t tok_q [POOL_ENTRIES];
  ent_t ent_q [POOL_ENTRIES];
  ent_t nbr   [POOL_ENTRIES];

  logic accept;
  logic busy_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                     pend_vld_r;
  status_t                  pend_st_r;
  logic [VALUE_W-1:0]       pend_rdv_r;
  logic [ENTRY_COUNT_W-1:0] pend_cnt_r;

  logic                     out_vld_r;
  status_t                  out_st_r;
  logic [VALUE_W-1:0]       out_rdv_r;
  logic [ENTRY_COUNT_W-1:0] out_cnt_r;

  tok_t    tail;
  status_t tail_st;
  logic    out_load;

  assign in_req.ready = !busy_r;
  assign accept       = in_req.valid && !busy_r;

  always_comb begin
    tok_in        = '0;
    tok_in.act    = accept;
    tok_in.op     = op_t'(in_req.opcode);
    tok_in.key    = in_req.key;
    tok_in.value  = in_req.value;
    tok_in.done   = (op_t'(in_req.opcode) == OP_NOP);
    tok_in.status = ST_OK;
  end

  genvar g;
  generate
    for (g = 0; g < POOL_ENTRIES; g++) begin : g_cell
      if (g == POOL_ENTRIES - 1) begin : g_last
        assign nbr[g] = '0;
      end else begin : g_mid
        assign nbr[g] = ent_q[g+1];
      end
      if (g == 0) begin : g_head
        chme_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .tok_i(tok_in),
          .nbr_i(nbr[g]),
          .ent_o(ent_q[g]),
          .tok_o(tok_q[g])
        );
      end else begin : g_body
        chme_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .tok_i(tok_q[g-1]),
          .nbr_i(nbr[g]),
          .ent_o(ent_q[g]),
          .tok_o(tok_q[g])
        );
      end
    end
  endgenerate

  assign tail = tok_q[POOL_ENTRIES-1];

  // a token that ran off the end found neither its key nor an empty cell
  always_comb begin
    tail_st = tail.status;
    if (!tail.done) tail_st = (tail.op == OP_STORE) ? ST_FULL : ST_MISS;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (tail.act && tail.op == OP_STORE && tail.ins)
      cnt_nxt = cnt_r + CNT_W'(1);
    else if (tail.act && tail.op == OP_DELETE && tail.done && tail.status == ST_OK)
      cnt_nxt = cnt_r - CNT_W'(1);
  end

  assign out_load = pend_vld_r && (!out_vld_r || out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept)        busy_r <= 1'b1;
      else if (out_load) busy_r <= 1'b0;
      if (tail.act)      pend_vld_r <= 1'b1;
      else if (out_load) pend_vld_r <= 1'b0;
      if (out_load)           out_vld_r <= 1'b1;
      else if (out_rsp.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.act) begin
      pend_st_r  <= tail_st;
      pend_rdv_r <= tail.rdv;
      pend_cnt_r <= ENTRY_COUNT_W'(cnt_nxt);
    end
    if (out_load) begin
      out_st_r  <= pend_st_r;
      out_rdv_r <= pend_rdv_r;
      out_cnt_r <= pend_cnt_r;
    end
  end

  assign out_rsp.valid       = out_vld_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.read_value  = out_rdv_r;
  assign out_rsp.entry_count = out_cnt_r;

endmodule

/* tb/chained_hash_map_engine_test.sv */
module chained_hash_map_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chme_pkg::*;

  localparam int unsigned POOL_SIZE  = 256;
  localparam int          RAND_ITEMS = 1826;
  localparam int          FILL_END   = 450;
  localparam int          DRAIN_END  = 1050;
  localparam int          HOLDOFF_AT = 1300;
  localparam int          HOLDOFF_CY = 1500;
  localparam int          DIR_ROWS   = 24;
  localparam int          KEY_HIST   = 600;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   read_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } map_reply_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               fixed;   // reply typed in below, not taken from the map model
    map_reply_t         reply;
  } map_request_row_t;

  logic clk = 1'b0;
  logic rst_n;

  chme_req_if req_bus ();
  chme_rsp_if rsp_bus ();

  chained_hash_map_engine #(
    .POOL_ENTRIES(POOL_SIZE)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  always #10 clk = ~clk;

  // map model state
  logic [VALUE_W-1:0] map_values [logic [KEY_W-1:0]];
  int unsigned        map_entries = 0;

  map_reply_t         expected_replies [$];
  logic [KEY_W-1:0]   stored_keys [$];
  logic [23:0]        hi_choices [8];
  int                 fail_count = 0;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 rsp_holdoff = 0;

  // directed rows: keys 0x200, 0x100 and 0x000 all share the low byte 0x00
  map_request_row_t directed_rows [DIR_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 64'h0, 1'b1, '{ST_MISS, 64'h0, 9'd0}},
    '{OP_DELETE, 32'hFFFF_FFFF, 64'h0, 1'b1, '{ST_MISS, 64'h0, 9'd0}},
    '{OP_NOP,    32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 64'h0, 9'd0}},
    '{OP_STORE,  32'h0000_0000, 64'h0, 1'b1, '{ST_OK, 64'h0, 9'd1}},
    '{OP_STORE,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 64'h0, 9'd2}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_OK, 64'hFFFF_FFFF_FFFF_FFFF, 9'd2}},
    '{OP_STORE,  32'h0000_0100, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{OP_STORE,  32'h0000_0200, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_0000, 64'h0, 1'b0, '0},
    '{OP_STORE,  32'h0000_0100, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_0100, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0100, 64'h0, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_0100, 64'h0, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_0200, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0000, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0200, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0000, 64'h0, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_0300, 64'h0, 1'b0, '0},
    '{OP_NOP,    32'h0000_0000, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'hFFFF_FFFF, 64'h0, 1'b0, '0},
    '{OP_STORE,  32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{OP_LOOKUP, 32'h8000_0000, 64'h0, 1'b0, '0},
    '{OP_DELETE, 32'h8000_0000, 64'h0, 1'b0, '0},
    '{OP_LOOKUP, 32'h8000_0000, 64'h0, 1'b0, '0}
  };

  function automatic map_reply_t apply_map_request(input op_t op, input logic [KEY_W-1:0] key,
                                                   input logic [VALUE_W-1:0] value);
    map_reply_t r;
    r.status     = ST_OK;
    r.read_value = '0;
    case (op)
      OP_STORE: begin
        if (map_values.exists(key)) begin
          map_values[key] = value;
        end else if (map_entries >= POOL_SIZE) begin
          r.status = ST_FULL;
        end else begin
          map_values[key] = value;
          map_entries++;
        end
      end
      OP_LOOKUP: begin
        if (map_values.exists(key)) r.read_value = map_values[key];
        else r.status = ST_MISS;
      end
      OP_DELETE: begin
        if (map_values.exists(key)) begin
          map_values.delete(key);
          map_entries--;
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    r.entry_count = ENTRY_COUNT_W'(map_entries);
    return r;
  endfunction

  function automatic op_t pick_op(input int w_store, input int w_lookup, input int w_delete);
    int r = $urandom_range(99);
    if (r < w_store) return OP_STORE;
    if (r < w_store + w_lookup) return OP_LOOKUP;
    if (r < w_store + w_lookup + w_delete) return OP_DELETE;
    return OP_NOP;
  endfunction

  // keys: reused, from a small colliding set, fresh but crowded into 64 slots, or anything
  function automatic logic [KEY_W-1:0] pick_key(input int pct_used, input int pct_small,
                                                input int pct_fresh);
    int r = $urandom_range(99);
    if (r < pct_used && stored_keys.size() != 0)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (r < pct_used + pct_small)
      return {hi_choices[$urandom_range(7)], 8'($urandom_range(63))};
    if (r < pct_used + pct_small + pct_fresh)
      return {24'($urandom), 8'($urandom_range(63))};
    return $urandom;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value, input logic fixed,
                              input map_reply_t fixed_reply);
    map_reply_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= op;
    req_bus.key    <= key;
    req_bus.value  <= value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r = apply_map_request(op, key, value);
    expected_replies.push_back(fixed ? fixed_reply : r);
    if (op == OP_STORE && r.status == ST_OK) begin
      stored_keys.push_back(key);
      if (stored_keys.size() > KEY_HIST) void'(stored_keys.pop_front());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : request_source
    op_t              op;
    logic [KEY_W-1:0] key;
    req_bus.valid  = 1'b0;
    req_bus.opcode = '0;
    req_bus.key    = '0;
    req_bus.value  = '0;
    send_idle_pct  = 19;
    recv_idle_pct  = 72;
    hi_choices[0]  = 24'h000000;
    hi_choices[1]  = 24'hFFFFFF;
    for (int i = 2; i < 8; i++) hi_choices[i] = 24'($urandom);
    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].fixed, directed_rows[i].reply);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 19;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == HOLDOFF_AT) rsp_holdoff = HOLDOFF_CY;
      if (n < FILL_END) begin
        // store-heavy so the pool runs full
        op  = pick_op(85, 10, 3);
        key = (op == OP_STORE) ? pick_key(15, 25, 55) : pick_key(70, 20, 5);
      end else if (n < DRAIN_END) begin
        op  = pick_op(25, 35, 35);
        key = pick_key(60, 30, 5);
      end else begin
        op  = pick_op(45, 30, 20);
        key = pick_key(45, 30, 20);
      end
      send_request(op, key, pick_value(), 1'b0, '0);
    end
    req_bus.valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (POOL_SIZE + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : reply_sink
    map_reply_t want;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat: status %0d value %h count %0d", $realtime,
                   rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_bus.status !== want.status || rsp_bus.read_value !== want.read_value ||
              rsp_bus.entry_count !== want.entry_count) begin
            fail_count++;
            $display("%0t: mismatch: expected status %0d value %h count %0d,",
                     $realtime, want.status, want.read_value, want.entry_count,
                     " got status %0d value %h count %0d",
                     rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
          end
        end
      end
      // long hold-off lets both result slots fill so the input stalls
      if (rsp_holdoff != 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_holdoff--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(50_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/chme_pkg.sv
rtl/chme_if.sv
rtl/chme_cell.sv
rtl/chained_hash_map_engine.sv
tb/chained_hash_map_engine_test.sv
